// ----- rtl/core/ubx_frame_builder_core_assert.svh -----
// Assertion macros for the frame builder core.
`ifndef UBX_FRAME_BUILDER_CORE_ASSERT_SVH
`define UBX_FRAME_BUILDER_CORE_ASSERT_SVH

// clocked check, off while in reset
`define UBX_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check, active through reset
`define UBX_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ubx_pkg.sv -----
`default_nettype none

package ubx_pkg;

	localparam logic [7:0] SYNC_ONE = 8'hB5;
	localparam logic [7:0] SYNC_TWO = 8'h62;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	typedef logic [2:0] step_t;

	// start word sequence
	localparam step_t ST_SYNC1  = 3'd0;
	localparam step_t ST_SYNC2  = 3'd1;
	localparam step_t ST_CLASS  = 3'd2;
	localparam step_t ST_ID     = 3'd3;
	localparam step_t ST_LEN_LO = 3'd4;
	localparam step_t ST_LEN_HI = 3'd5;
	localparam step_t ST_CK_A   = 3'd6;
	localparam step_t ST_CK_B   = 3'd7;

	// payload word sequence
	localparam step_t DT_BYTE = 3'd0;
	localparam step_t DT_CK_A = 3'd1;
	localparam step_t DT_CK_B = 3'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] len;
		logic       last;
	} op_t;

endpackage

`default_nettype wire

// ----- rtl/core/ubx_frame_builder_core.sv -----
// channel | handshake            | words
// in      | in_valid / in_ready  | command, data_byte, msg_class, msg_id, payload_length
// out     | out_valid / out_ready| frame_byte, end_of_frame
//
// A payload word yields one output byte, three when it closes the frame.
// A start word yields six output bytes, eight for an empty frame; the byte sequencer sets this.
// Input and output are decoupled by a FIFO_DEPTH-entry word queue plus the output register.
// Reset is asynchronous, active low; nothing is emitted until the first start word.
// out_ready low with a word held stalls the sequencer only; inputs keep flowing until the queue fills.
`default_nettype none

module ubx_frame_builder_core
	import ubx_pkg::*;
#(
	parameter int FIFO_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       command,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] msg_class,
	input  wire logic [7:0] msg_id,
	input  wire logic [7:0] payload_length,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      frame_byte,
	output logic            end_of_frame
);

	logic push;
	op_t  push_op;
	logic full;
	logic pop;
	logic head_valid;
	op_t  head_op;

	ubx_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.data_byte      (data_byte),
		.msg_class      (msg_class),
		.msg_id         (msg_id),
		.payload_length (payload_length),
		.push           (push),
		.push_op        (push_op),
		.full           (full)
	);

	ubx_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	ubx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_op      (head_op),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_byte   (frame_byte),
		.end_of_frame (end_of_frame)
	);

endmodule

`default_nettype wire

// ----- rtl/core/ubx_front.sv -----
`default_nettype none

module ubx_front
	import ubx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       command,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] msg_class,
	input  wire logic [7:0] msg_id,
	input  wire logic [7:0] payload_length,
	output logic            push,
	output op_t             push_op,
	input  wire logic       full
);

	logic       in_frame_q;
	logic [7:0] rem_q;
	logic       acc;

	assign in_ready = !full;
	assign acc      = in_valid && in_ready;
	assign push     = acc && (command == CMD_START || in_frame_q);

	always_comb begin
		push_op.kind = command;
		push_op.b0   = (command == CMD_START) ? msg_class : data_byte;
		push_op.b1   = msg_id;
		push_op.len  = payload_length;
		push_op.last = (command == CMD_START) ? (payload_length == 8'd0) : (rem_q == 8'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			rem_q      <= 8'd0;
		end else if (acc) begin
			if (command == CMD_START) begin
				in_frame_q <= (payload_length != 8'd0);
				rem_q      <= payload_length;
			end else if (in_frame_q) begin
				rem_q <= rem_q - 8'd1;
				if (rem_q == 8'd1) begin
					in_frame_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ubx_fifo.sv -----
`default_nettype none

module ubx_fifo
	import ubx_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output op_t       head_op
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_op    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ubx_back.sv -----
`default_nettype none

module ubx_back
	import ubx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       head_valid,
	input  wire op_t        head_op,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      frame_byte,
	output logic            end_of_frame
);

	step_t      step_q;
	logic       ov_q;
	logic [7:0] byte_q;
	logic       eof_q;
	logic [7:0] sum_a_q;
	logic [7:0] sum_b_q;

	logic       adv;
	logic [7:0] nbyte;
	logic       summed;
	logic       clear;
	logic       fin;
	logic       eof;
	logic [7:0] na;
	logic [7:0] nb;

	assign adv          = head_valid && (!ov_q || out_ready);
	assign pop          = adv && fin;
	assign out_valid    = ov_q;
	assign frame_byte   = byte_q;
	assign end_of_frame = eof_q;
	assign na           = sum_a_q + nbyte;
	assign nb           = sum_b_q + na;

	always_comb begin
		nbyte  = 8'd0;
		summed = 1'b0;
		clear  = 1'b0;
		fin    = 1'b0;
		eof    = 1'b0;
		if (head_op.kind == CMD_START) begin
			case (step_q)
				ST_SYNC1: begin
					nbyte = SYNC_ONE;
					clear = 1'b1;
				end
				ST_SYNC2: nbyte = SYNC_TWO;
				ST_CLASS: begin
					nbyte  = head_op.b0;
					summed = 1'b1;
				end
				ST_ID: begin
					nbyte  = head_op.b1;
					summed = 1'b1;
				end
				ST_LEN_LO: begin
					nbyte  = head_op.len;
					summed = 1'b1;
				end
				ST_LEN_HI: begin
					nbyte  = 8'd0;
					summed = 1'b1;
					fin    = !head_op.last;
				end
				ST_CK_A: nbyte = sum_a_q;
				ST_CK_B: begin
					nbyte = sum_b_q;
					eof   = 1'b1;
					fin   = 1'b1;
				end
				default: begin
					nbyte = sum_b_q;
					eof   = 1'b1;
					fin   = 1'b1;
				end
			endcase
		end else begin
			case (step_q)
				DT_BYTE: begin
					nbyte  = head_op.b0;
					summed = 1'b1;
					fin    = !head_op.last;
				end
				DT_CK_A: nbyte = sum_a_q;
				default: begin
					nbyte = sum_b_q;
					eof   = 1'b1;
					fin   = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= nbyte;
			eof_q  <= eof;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			step_q  <= ST_SYNC1;
			sum_a_q <= 8'd0;
			sum_b_q <= 8'd0;
		end else if (adv) begin
			ov_q   <= 1'b1;
			step_q <= fin ? ST_SYNC1 : step_q + 3'd1;
			if (clear) begin
				sum_a_q <= 8'd0;
				sum_b_q <= 8'd0;
			end else if (summed) begin
				sum_a_q <= na;
				sum_b_q <= nb;
			end
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ubx_chk.sv -----
`default_nettype none

`include "ubx_frame_builder_core_assert.svh"

module ubx_chk
	import ubx_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       command,
	input wire logic [7:0] payload_length,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] frame_byte,
	input wire logic       end_of_frame
);

	logic        in_frame_q;
	logic [7:0]  rem_q;
	logic [15:0] pend_q;
	logic [7:0]  frames_q;

	logic        in_acc;
	logic        out_acc;
	logic [15:0] add;
	logic        closes;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_comb begin
		add    = 16'd0;
		closes = 1'b0;
		if (in_acc) begin
			if (command == CMD_START) begin
				closes = (payload_length == 8'd0);
				add    = closes ? 16'd8 : 16'd6;
			end else if (in_frame_q) begin
				closes = (rem_q == 8'd1);
				add    = closes ? 16'd3 : 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			rem_q      <= 8'd0;
			pend_q     <= 16'd0;
			frames_q   <= 8'd0;
		end else begin
			if (in_acc) begin
				if (command == CMD_START) begin
					in_frame_q <= (payload_length != 8'd0);
					rem_q      <= payload_length;
				end else if (in_frame_q) begin
					rem_q <= rem_q - 8'd1;
					if (rem_q == 8'd1) begin
						in_frame_q <= 1'b0;
					end
				end
			end
			pend_q   <= pend_q + add - {15'd0, out_acc};
			frames_q <= frames_q + {7'd0, closes} - {7'd0, out_acc && end_of_frame};
		end
	end

	`UBX_ASSERT_RST(a_reset_idle, !arst_n |=> !out_valid, "output valid right after reset")
	`UBX_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(end_of_frame), "stalled output word changed")
	`UBX_ASSERT_CLK(a_no_extra_word, out_valid |-> pend_q != 16'd0, "output word not caused by any input")
	`UBX_ASSERT_CLK(a_no_extra_eof, out_acc && end_of_frame |-> frames_q != 8'd0, "end of frame with no closed frame pending")

endmodule

bind ubx_frame_builder_core ubx_chk u_chk (.*);

`default_nettype wire

// ----- verif/ubx_frame_checker.sv -----
`default_nettype none

module ubx_frame_checker
	import ubx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic       command,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] msg_class,
	input  wire logic [7:0] msg_id,
	input  wire logic [7:0] payload_length,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] frame_byte,
	input  wire logic       end_of_frame,
	output int              fail_count,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} frame_word_t;

	frame_word_t expected_bytes[$];
	logic        open_frame;
	logic [7:0]  left_count;
	logic [7:0]  ck_a;
	logic [7:0]  ck_b;
	int          result_index;

	function void queue_byte(logic [7:0] value, logic last);
		frame_word_t w;
		w.value = value;
		w.last = last;
		expected_bytes.push_back(w);
	endfunction

	function void queue_summed(logic [7:0] value);
		ck_a = ck_a + value;
		ck_b = ck_b + ck_a;
		queue_byte(value, 1'b0);
	endfunction

	function void queue_checksum();
		queue_byte(ck_a, 1'b0);
		queue_byte(ck_b, 1'b1);
		open_frame = 1'b0;
		left_count = 8'd0;
	endfunction

	function void predict_frame_bytes(logic cmd, logic [7:0] data, logic [7:0] cls,
			logic [7:0] id, logic [7:0] len);
		if (cmd == CMD_START) begin
			ck_a = 8'd0;
			ck_b = 8'd0;
			queue_byte(SYNC_ONE, 1'b0);
			queue_byte(SYNC_TWO, 1'b0);
			queue_summed(cls);
			queue_summed(id);
			queue_summed(len);
			queue_summed(8'd0);
			if (len == 8'd0) begin
				queue_checksum();
			end else begin
				open_frame = 1'b1;
				left_count = len;
			end
		end else if (open_frame) begin
			queue_summed(data);
			left_count = left_count - 8'd1;
			if (left_count == 8'd0)
				queue_checksum();
		end
	endfunction

	function void report_mismatch(string what);
		if (fail_count < 10)
			$display("result %0d: %s", result_index, what);
		fail_count++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_word_t exp_word;
		if (!arst_n) begin
			expected_bytes.delete();
			open_frame = 1'b0;
			left_count = 8'd0;
			ck_a = 8'd0;
			ck_b = 8'd0;
			result_index = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (in_valid && in_ready)
				predict_frame_bytes(command, data_byte, msg_class, msg_id, payload_length);
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected word, got byte %02h end %0b",
						frame_byte, end_of_frame));
				end else begin
					exp_word = expected_bytes.pop_front();
					if (frame_byte !== exp_word.value || end_of_frame !== exp_word.last)
						report_mismatch($sformatf(
							"expected byte %02h end %0b, got byte %02h end %0b",
							exp_word.value, exp_word.last, frame_byte, end_of_frame));
				end
				result_index++;
			end
			pending = expected_bytes.size();
		end
	end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ubx_pkg::*;

	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 200;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       command = CMD_START;
	logic [7:0] data_byte = 8'd0;
	logic [7:0] msg_class = 8'd0;
	logic [7:0] msg_id = 8'd0;
	logic [7:0] payload_length = 8'd0;
	logic       out_ready = 1'b0;
	wire        in_ready;
	wire        out_valid;
	wire  [7:0] frame_byte;
	wire        end_of_frame;
	int         fail_count;
	int         pending;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_trigger = 0;
	int words_sent = 0;

	always #1 clk = ~clk;

	ubx_frame_builder_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.data_byte      (data_byte),
		.msg_class      (msg_class),
		.msg_id         (msg_id),
		.payload_length (payload_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_byte     (frame_byte),
		.end_of_frame   (end_of_frame)
	);

	ubx_frame_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.data_byte      (data_byte),
		.msg_class      (msg_class),
		.msg_id         (msg_id),
		.payload_length (payload_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_byte     (frame_byte),
		.end_of_frame   (end_of_frame),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	// receiver: random stalls, plus a long hold-off on request
	initial begin : receiver
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_word(input logic cmd, input logic [7:0] data, input logic [7:0] cls,
			input logic [7:0] id, input logic [7:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		command = cmd;
		data_byte = data;
		msg_class = cls;
		msg_id = id;
		payload_length = len;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_start(input logic [7:0] cls, input logic [7:0] id,
			input logic [7:0] len);
		send_word(CMD_START, 8'($urandom), cls, id, len);
	endtask

	task automatic send_payload(input logic [7:0] data);
		send_word(CMD_DATA, data, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// mostly complete frames; some cut short by the next start, some stray bytes after
	task automatic random_frame();
		logic [7:0] len;
		int         cut;
		int         roll;
		roll = $urandom_range(99);
		if (roll < 70)
			len = 8'($urandom_range(0, 8));
		else if (roll < 95)
			len = 8'($urandom_range(9, 40));
		else
			len = 8'($urandom_range(41, 120));
		cut = len;
		if (len > 1 && $urandom_range(9) == 0)
			cut = $urandom_range(0, len - 1);
		send_start(8'($urandom), 8'($urandom), len);
		words_sent++;
		for (int i = 0; i < cut; i++) begin
			send_payload(8'($urandom));
			words_sent++;
		end
		if (cut == len && $urandom_range(4) == 0)
			send_payload(8'($urandom));
	endtask

	task automatic run_phase(input int s_pct, input int r_pct, input int words);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		words_sent = 0;
		while (words_sent < words)
			random_frame();
		wait_drained();
	endtask

	initial begin
		#400000;
		$display("ubx_frame_builder_core test failed");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 23;
		recv_idle_pct = 64;
		// bytes before any frame are dropped
		send_payload(8'hFF);
		send_payload(8'h00);
		// empty frames
		send_start(8'h00, 8'h00, 8'h00);
		send_start(8'hFF, 8'hFF, 8'h00);
		send_start(8'h06, 8'h01, 8'd3);
		send_payload(8'h00);
		send_payload(8'hFF);
		send_payload(8'hA5);
		send_payload(8'h3C);
		// longest length, abandoned by a new start
		send_start(8'hAA, 8'h55, 8'hFF);
		send_payload(8'h12);
		send_payload(8'h34);
		send_start(8'h01, 8'h02, 8'd1);
		send_payload(8'hFF);
		send_start(8'hFF, 8'h00, 8'd2);
		send_payload(8'hFF);
		send_payload(8'hFF);
		wait_drained();

		// receiver holds off while the sender streams a frame
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_trigger++;
		@(negedge clk);
		send_start(8'h0A, 8'h04, 8'd40);
		for (int i = 0; i < 40; i++)
			send_payload(8'($urandom));
		wait_drained();

		run_phase(23, 64, 100);
		run_phase(64, 23, 100);
		run_phase(0, 0, 100);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ubx_frame_builder_core test passed");
		else
			$display("ubx_frame_builder_core test failed");
		$finish;
	end

endmodule

`default_nettype wire
